### design/gripr_pkg.sv
package gripr_pkg;

    localparam int POS_FULL     = 20000;
    localparam int ANGLE_TOP    = 180;
    localparam int EFFORT_BASE  = 199;
    localparam int EFFORT_FIRST = 200;
    localparam int EFFORT_LAST  = 300;
    localparam int EFFORT_CEIL  = 1200;
    localparam int EFFORT_RESET = 300;
    localparam int ALPHA_ONE    = 256;

    // duty = (1150 + pos*19/400) * 256 / 625
    localparam int POS_GAIN    = 19;
    localparam int DIV_POS     = 400;
    localparam int DIV_DUTY    = 625;
    localparam int PULSE_LOW   = 1150;
    localparam int QUOT_BITS   = 10;
    localparam int ALPHA_BITS  = 9;

    localparam logic [2:0] CFG_ALPHA   = 3'd0;
    localparam logic [2:0] CFG_IDLE    = 3'd1;
    localparam logic [2:0] CFG_MAX     = 3'd2;
    localparam logic [2:0] CFG_MIN     = 3'd3;
    localparam logic [2:0] CFG_BACKOFF = 3'd4;

    typedef struct packed {
        logic [8:0]  alpha_q8;
        logic [11:0] idle_seed_ma;
        logic [14:0] max_step;
        logic [14:0] min_step;
        logic [14:0] backoff_step;
    } cfg_regs_t;

    typedef logic [14:0] angle_lut_t [0:ANGLE_TOP];

    function automatic angle_lut_t build_angle_lut();
        angle_lut_t lut;
        for (int i = 0; i <= ANGLE_TOP; i++) begin
            lut[i] = 15'(i * POS_FULL / ANGLE_TOP);
        end
        return lut;
    endfunction

    localparam angle_lut_t ANGLE_LUT = build_angle_lut();

endpackage

### design/effort_limited_gripper_regulator.sv
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  mode, measured_current, command_code
// out       source     out_valid / out_stall pwm_duty, position, filtered_current,
//                                           command_ignored, overload
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item at a time. A command goes through two 10-step duty divisions into the
// output register; a tick first runs the 9-step serial alpha multiply and the
// regulation states REG1 and REG2 ahead of them.
// in_stall is high from acceptance until the result is in the output register,
// longer while the previous beat still waits there on out_stall.
// Async active-low reset: position and target fully open, effort 300 mA,
// filter state zero, config at its defaults. cfg_ready is always high.
module effort_limited_gripper_regulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [11:0] measured_current,
    input  logic [8:0]  command_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [12:0] pwm_duty,
    output logic [14:0] position,
    output logic [11:0] filtered_current,
    output logic        command_ignored,
    output logic        overload,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import gripr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FILT, ST_REG1, ST_REG2, ST_DUTY, ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    cfg_regs_t   cfg_reg, cfg_next;
    logic [14:0] pos_reg, pos_next;
    logic [14:0] tgt_reg, tgt_next;
    logic [10:0] effort_reg, effort_next;
    logic [14:0] step_reg, step_next;
    logic        gap_pos_reg, gap_pos_next;
    logic        ignored_reg, ignored_next;
    logic        over_reg, over_next;
    logic        out_valid_reg, out_valid_next;
    logic [12:0] duty_out_reg, duty_out_next;
    logic [14:0] pos_out_reg, pos_out_next;
    logic [11:0] cur_out_reg, cur_out_next;
    logic        ign_out_reg, ign_out_next;
    logic        over_out_reg, over_out_next;

    logic        in_accept;
    logic        filt_start, filt_done;
    logic [19:0] filt_q8;
    logic        duty_start, duty_done;
    logic [12:0] duty;

    logic [6:0]  eff_idx;
    logic [10:0] eff_ma;
    logic signed [13:0] gap;
    logic [14:0] gap_u;
    logic [14:0] step_raw;
    logic [14:0] span;
    logic [15:0] back_sum;
    logic        load;

    gripr_filter u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (filt_start),
        .meas    (measured_current),
        .cfg     (cfg_reg),
        .done    (filt_done),
        .filt_q8 (filt_q8)
    );

    gripr_duty u_duty (
        .clk   (clk),
        .rst_n (rst_n),
        .start (duty_start),
        .pos   (pos_next),
        .done  (duty_done),
        .duty  (duty)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign filt_start = in_accept && !mode;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        eff_idx  = 7'(command_code - 9'(EFFORT_BASE));
        eff_ma   = ({4'b0, eff_idx} << 3) + ({4'b0, eff_idx} << 2);
        gap      = $signed({3'b0, effort_reg}) - $signed({2'b0, filt_q8[19:8]});
        gap_u    = 15'(gap[12:0]);
        step_raw = gap_u + (gap_u >> 1);
        span     = pos_reg - tgt_reg;
        back_sum = {1'b0, pos_reg} + {1'b0, cfg_reg.backoff_step};
        load     = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

        state_next     = state_reg;
        cfg_next       = cfg_reg;
        pos_next       = pos_reg;
        tgt_next       = tgt_reg;
        effort_next    = effort_reg;
        step_next      = step_reg;
        gap_pos_next   = gap_pos_reg;
        ignored_next   = ignored_reg;
        over_next      = over_reg;
        duty_start     = 1'b0;
        duty_out_next  = duty_out_reg;
        pos_out_next   = pos_out_reg;
        cur_out_next   = cur_out_reg;
        ign_out_next   = ign_out_reg;
        over_out_next  = over_out_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ALPHA:   cfg_next.alpha_q8     = cfg_data[8:0];
                CFG_IDLE:    cfg_next.idle_seed_ma = cfg_data[11:0];
                CFG_MAX:     cfg_next.max_step     = cfg_data;
                CFG_MIN:     cfg_next.min_step     = cfg_data;
                CFG_BACKOFF: cfg_next.backoff_step = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    over_next    = 1'b0;
                    ignored_next = 1'b0;
                    if (mode)
                    begin
                        if (command_code <= 9'(ANGLE_TOP))
                            tgt_next = ANGLE_LUT[command_code[7:0]];
                        else if (command_code >= 9'(EFFORT_FIRST) &&
                                 command_code <= 9'(EFFORT_LAST))
                            effort_next = (eff_ma > 11'(EFFORT_CEIL)) ?
                                          11'(EFFORT_CEIL) : eff_ma;
                        else
                            ignored_next = 1'b1;
                        duty_start = 1'b1;
                        state_next = ST_DUTY;
                    end
                    else
                    begin
                        state_next = ST_FILT;
                    end
                end
            end
            ST_FILT:
            begin
                if (filt_done)
                    state_next = ST_REG1;
            end
            ST_REG1:
            begin
                gap_pos_next = !gap[13] && (gap != '0);
                if (step_raw < cfg_reg.min_step)
                    step_next = cfg_reg.min_step;
                else if (step_raw > cfg_reg.max_step)
                    step_next = cfg_reg.max_step;
                else
                    step_next = step_raw;
                state_next = ST_REG2;
            end
            ST_REG2:
            begin
                if (tgt_reg > pos_reg)
                begin
                    pos_next = tgt_reg;
                end
                else if (tgt_reg < pos_reg)
                begin
                    if (gap_pos_reg)
                    begin
                        pos_next = (span > step_reg) ? pos_reg - step_reg : tgt_reg;
                    end
                    else
                    begin
                        pos_next  = (back_sum > 16'(POS_FULL)) ? 15'(POS_FULL) :
                                    back_sum[14:0];
                        over_next = 1'b1;
                    end
                end
                duty_start = 1'b1;
                state_next = ST_DUTY;
            end
            ST_DUTY:
            begin
                if (duty_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load)
                begin
                    duty_out_next = duty;
                    pos_out_next  = pos_reg;
                    cur_out_next  = filt_q8[19:8];
                    ign_out_next  = ignored_reg;
                    over_out_next = over_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                <= ST_IDLE;
            cfg_reg.alpha_q8         <= 9'd33;
            cfg_reg.idle_seed_ma     <= 12'd110;
            cfg_reg.max_step         <= 15'd400;
            cfg_reg.min_step         <= 15'd10;
            cfg_reg.backoff_step     <= 15'd50;
            pos_reg                  <= 15'(POS_FULL);
            tgt_reg                  <= 15'(POS_FULL);
            effort_reg               <= 11'(EFFORT_RESET);
            step_reg                 <= '0;
            gap_pos_reg              <= 1'b0;
            ignored_reg              <= 1'b0;
            over_reg                 <= 1'b0;
            out_valid_reg            <= 1'b0;
            duty_out_reg             <= '0;
            pos_out_reg              <= '0;
            cur_out_reg              <= '0;
            ign_out_reg              <= 1'b0;
            over_out_reg             <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            pos_reg       <= pos_next;
            tgt_reg       <= tgt_next;
            effort_reg    <= effort_next;
            step_reg      <= step_next;
            gap_pos_reg   <= gap_pos_next;
            ignored_reg   <= ignored_next;
            over_reg      <= over_next;
            out_valid_reg <= out_valid_next;
            duty_out_reg  <= duty_out_next;
            pos_out_reg   <= pos_out_next;
            cur_out_reg   <= cur_out_next;
            ign_out_reg   <= ign_out_next;
            over_out_reg  <= over_out_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pwm_duty         = duty_out_reg;
    assign position         = pos_out_reg;
    assign filtered_current = cur_out_reg;
    assign command_ignored  = ign_out_reg;
    assign overload         = over_out_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 15'(POS_FULL))
        else $error("position out of range");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_REG2) |=> $stable(pos_reg))
        else $error("position moved outside regulation step");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result beat appeared without a finished item");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(ign_out_reg && over_out_reg))
        else $error("ignored command and overload flagged together");

endmodule

### design/gripr_filter.sv
module gripr_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [11:0]         meas,
    input  gripr_pkg::cfg_regs_t cfg,
    output logic                done,
    output logic [19:0]         filt_q8
);
    import gripr_pkg::*;

    typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_t;

    state_t             state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic signed [29:0] acc_reg, acc_next;
    logic signed [29:0] addend_reg, addend_next;
    logic [8:0]         mult_reg, mult_next;
    logic [19:0]        filt_reg, filt_next;
    logic               done_reg, done_next;

    logic [19:0]        seed;
    logic [8:0]         alpha_sat;
    logic signed [29:0] diff;
    logic signed [29:0] acc_sum;

    // acc = 256*f + a*(256*meas - f), alpha taken one bit per cycle
    always_comb
    begin
        seed      = (filt_reg == '0) ? {cfg.idle_seed_ma, 8'b0} : filt_reg;
        alpha_sat = (cfg.alpha_q8 > 9'(ALPHA_ONE)) ? 9'(ALPHA_ONE) : cfg.alpha_q8;
        diff      = $signed({10'b0, meas, 8'b0}) - $signed({10'b0, seed});
        acc_sum   = mult_reg[0] ? acc_reg + addend_reg : acc_reg;

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        addend_next = addend_reg;
        mult_next   = mult_reg;
        filt_next   = filt_reg;
        done_next   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    acc_next    = $signed({2'b0, seed, 8'b0});
                    addend_next = diff;
                    mult_next   = alpha_sat;
                    cnt_next    = 4'(ALPHA_BITS - 1);
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                acc_next    = acc_sum;
                addend_next = addend_reg <<< 1;
                mult_next   = mult_reg >> 1;
                cnt_next    = cnt_reg - 4'd1;
                if (cnt_reg == '0)
                begin
                    filt_next  = acc_sum[27:8];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            addend_reg <= '0;
            mult_reg   <= '0;
            filt_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            addend_reg <= addend_next;
            mult_reg   <= mult_next;
            filt_reg   <= filt_next;
            done_reg   <= done_next;
        end
    end

    assign done    = done_reg;
    assign filt_q8 = filt_reg;

endmodule

### design/gripr_duty.sv
module gripr_duty (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [14:0] pos,
    output logic        done,
    output logic [12:0] duty
);
    import gripr_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV_PULSE, ST_DIV_DUTY} state_t;

    state_t      state_reg, state_next;
    logic [19:0] rem_reg, rem_next;
    logic [19:0] dvs_reg, dvs_next;
    logic [9:0]  quot_reg, quot_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;

    logic [19:0] pos_w;
    logic        ge;
    logic [19:0] rem_after;
    logic [9:0]  quot_shift;
    logic [11:0] pulse;

    // restoring division, one quotient bit per cycle, divisor shifts right
    always_comb
    begin
        pos_w      = {5'b0, pos};
        ge         = rem_reg >= dvs_reg;
        rem_after  = ge ? rem_reg - dvs_reg : rem_reg;
        quot_shift = {quot_reg[8:0], ge};
        pulse      = 12'(PULSE_LOW) + {2'b0, quot_shift};

        state_next = state_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next   = (pos_w << 4) + (pos_w << 1) + pos_w;  // pos * POS_GAIN
                    dvs_next   = 20'(DIV_POS) << (QUOT_BITS - 1);
                    quot_next  = '0;
                    cnt_next   = 4'(QUOT_BITS - 1);
                    state_next = ST_DIV_PULSE;
                end
            end
            ST_DIV_PULSE:
            begin
                rem_next  = rem_after;
                dvs_next  = dvs_reg >> 1;
                quot_next = quot_shift;
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == '0)
                begin
                    rem_next   = {pulse, 8'b0};
                    dvs_next   = 20'(DIV_DUTY) << (QUOT_BITS - 1);
                    quot_next  = '0;
                    cnt_next   = 4'(QUOT_BITS - 1);
                    state_next = ST_DIV_DUTY;
                end
            end
            ST_DIV_DUTY:
            begin
                rem_next  = rem_after;
                dvs_next  = dvs_reg >> 1;
                quot_next = quot_shift;
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            quot_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            dvs_reg   <= dvs_next;
            quot_reg  <= quot_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign duty = {3'b0, quot_reg};

endmodule
